[src/cry_pkg.sv]
// Package for the RGB to CRY converter: widths, controller states and the
// constant chroma table built at elaboration. No dependencies.
package cry_pkg;

    localparam int COMP_W    = 8;             // one color component
    localparam int TBL_DEPTH = 256;           // 16x16 chroma cells
    localparam int TBL_AW    = 8;
    localparam int ENTRY_W   = 3 * COMP_W;    // {r, g, b}
    localparam int RAD_W     = 2 * COMP_W;    // radicand of the root unit
    localparam int SQ_STAGES = COMP_W;        // one root bit per stage
    localparam int DIV_STEPS = COMP_W;        // one quotient bit per step
    localparam int DIV_CW    = $clog2(DIV_STEPS);

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_IDLE,
        ST_DIV,
        ST_SEARCH,
        ST_DONE
    } cry_state_t;

    typedef logic [ENTRY_W-1:0] cry_tbl_t [TBL_DEPTH];

    // round half up of 255*num/den, found by search so only multiplies are used
    function automatic int frac_byte(input int num, input int den);
        int q;
        int lim;
        int k;
        q   = 0;
        lim = 510 * num + den;
        for (k = 1; k <= 255; k++)
        begin
            if (2 * den * k <= lim)
            begin
                q = k;
            end
        end
        return q;
    endfunction

    // normalized RGB of cell (column x, row y), quadrant formula
    function automatic logic [ENTRY_W-1:0] cell_rgb(input int x, input int y);
        int r;
        int g;
        int b;
        int d;
        if (x < 8 && y <= 15 - x)
        begin
            r = frac_byte(x, 8);
            g = frac_byte(y, 15 - x);
            b = 255;
        end
        else if (x >= 8 && y < x)
        begin
            r = 255;
            g = frac_byte(y, x);
            b = frac_byte(15 - x, 8);
        end
        else if (x < 8)
        begin
            d = x + y - 15;
            if (d < 0)
            begin
                d = -d;
            end
            r = frac_byte(15 - y, 8);
            g = 255;
            b = frac_byte(8 - d, 8);
        end
        else
        begin
            d = y - x;
            if (d < 0)
            begin
                d = -d;
            end
            r = frac_byte(8 - d, 8);
            g = 255;
            b = frac_byte(15 - y, 8);
        end
        return {COMP_W'(r), COMP_W'(g), COMP_W'(b)};
    endfunction

    function automatic cry_tbl_t build_table();
        cry_tbl_t t;
        int i;
        for (i = 0; i < TBL_DEPTH; i++)
        begin
            t[i] = cell_rgb(i & 15, i >> 4);
        end
        return t;
    endfunction

    // entry index = row*16 + column
    localparam cry_tbl_t CRY_TABLE = build_table();

endpackage

[src/cry_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read.
// Defaults come from cry_pkg.
module cry_ram #(
    parameter int WIDTH = cry_pkg::ENTRY_W,
    parameter int DEPTH = cry_pkg::TBL_DEPTH,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[src/rgb_to_cry_color_converter_top.sv]
// RGB to CRY converter, top level. Uses cry_pkg and cry_ram.
// Sequence: the request is accepted, 8 divide steps run, then 256 table reads
//   (one per cycle from the RAM port) pass the read, square, sum and root stages,
//   and the result register is loaded. No new request is taken until then.
// Reset: asynchronous, active low. After reset all 256 entries of the table RAM
//   are loaded; req_ready stays low until that is done.
module rgb_to_cry_color_converter_top (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       req_valid,
    output logic                       req_ready,
    input  logic [cry_pkg::COMP_W-1:0] red,
    input  logic [cry_pkg::COMP_W-1:0] green,
    input  logic [cry_pkg::COMP_W-1:0] blue,
    output logic                       rsp_valid,
    input  logic                       rsp_ready,
    output logic [cry_pkg::COMP_W-1:0] chroma_byte,
    output logic [cry_pkg::COMP_W-1:0] intensity,
    output logic                       no_match
);
    import cry_pkg::*;

    localparam logic [TBL_AW-1:0] LAST_IDX = TBL_AW'(TBL_DEPTH - 1);
    localparam int                BEST_W   = COMP_W + 1;   // holds 256 as "none yet"

    // ---------------------------------------------------------------------
    // Controller
    // ---------------------------------------------------------------------
    cry_state_t state_reg, state_next;
    logic [TBL_AW-1:0] cnt_reg, cnt_next;       // load address, then read address
    logic              issue_reg, issue_next;   // table reads still to be issued
    logic [DIV_CW-1:0] div_cnt_reg, div_cnt_next;

    // Normalization divider: three lanes, one quotient bit each per cycle.
    // Dividend c*255 < 256*intensity, so the top byte seeds the remainder.
    logic [COMP_W-1:0] inten_reg, inten_next;
    logic [COMP_W-1:0] rem_reg [3];
    logic [COMP_W-1:0] rem_next [3];
    logic [COMP_W-1:0] low_reg [3];
    logic [COMP_W-1:0] low_next [3];
    logic [COMP_W-1:0] quo_reg [3];             // normalized components when done
    logic [COMP_W-1:0] quo_next [3];
    logic [COMP_W-1:0] comp [3];
    logic [COMP_W:0]   rem9 [3];
    logic [RAD_W-1:0]  dvd [3];
    logic [COMP_W-1:0] max_rg;
    logic [COMP_W-1:0] max_rgb;

    // Table RAM
    logic              ram_we;
    logic [ENTRY_W-1:0] ram_rdata;

    // Search pipeline: RAM read -> square -> sum -> root stages -> compare
    logic              issue_v;
    logic              rd_v_reg, rd_v_next;
    logic              rd_last_reg, rd_last_next;
    logic [TBL_AW-1:0] rd_idx_reg, rd_idx_next;

    logic              mul_v_reg, mul_v_next;
    logic              mul_last_reg, mul_last_next;
    logic [TBL_AW-1:0] mul_idx_reg, mul_idx_next;
    logic [RAD_W-1:0]  mul_sq_reg [3];
    logic [RAD_W-1:0]  mul_sq_next [3];
    logic [COMP_W-1:0] ent [3];
    logic [COMP_W-1:0] diff [3];

    logic              sum_v_reg, sum_v_next;
    logic              sum_last_reg, sum_last_next;
    logic [TBL_AW-1:0] sum_idx_reg, sum_idx_next;
    logic              sum_big_reg, sum_big_next;      // squared distance >= 65536
    logic [RAD_W-1:0]  sum_val_reg, sum_val_next;
    logic [RAD_W+1:0]  sum_full;

    logic              rt_v_reg [SQ_STAGES];
    logic              rt_v_next [SQ_STAGES];
    logic              rt_last_reg [SQ_STAGES];
    logic              rt_last_next [SQ_STAGES];
    logic [TBL_AW-1:0] rt_idx_reg [SQ_STAGES];
    logic [TBL_AW-1:0] rt_idx_next [SQ_STAGES];
    logic              rt_big_reg [SQ_STAGES];
    logic              rt_big_next [SQ_STAGES];
    logic [RAD_W-1:0]  rt_rem_reg [SQ_STAGES];
    logic [RAD_W-1:0]  rt_rem_next [SQ_STAGES];
    logic [RAD_W:0]    rt_root_reg [SQ_STAGES];
    logic [RAD_W:0]    rt_root_next [SQ_STAGES];

    logic              fin_v;
    logic              fin_last;
    logic [BEST_W-1:0] fin_dist;

    logic [BEST_W-1:0] best_reg, best_next;
    logic [TBL_AW-1:0] best_idx_reg, best_idx_next;
    logic              found_reg, found_next;

    // Result register
    logic              rsp_valid_reg, rsp_valid_next;
    logic [COMP_W-1:0] chroma_reg, chroma_next;
    logic [COMP_W-1:0] inten_out_reg, inten_out_next;
    logic              nomatch_reg, nomatch_next;

    assign comp[0] = red;
    assign comp[1] = green;
    assign comp[2] = blue;

    assign max_rg  = (red > green) ? red : green;
    assign max_rgb = (max_rg > blue) ? max_rg : blue;

    assign req_ready   = (state_reg == ST_IDLE);
    assign issue_v     = (state_reg == ST_SEARCH) && issue_reg;
    assign ram_we      = (state_reg == ST_LOAD);

    assign fin_v    = rt_v_reg[SQ_STAGES-1] && !rt_big_reg[SQ_STAGES-1];
    assign fin_last = rt_v_reg[SQ_STAGES-1] && rt_last_reg[SQ_STAGES-1];
    assign fin_dist = rt_root_reg[SQ_STAGES-1][BEST_W-1:0];   // root <= 255

    // Constant table copied into the RAM after reset, one entry a cycle.
    cry_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TBL_DEPTH)
    ) u_tbl (
        .clk   (clk),
        .we    (ram_we),
        .waddr (cnt_reg),
        .wdata (CRY_TABLE[cnt_reg]),
        .raddr (cnt_reg),
        .rdata (ram_rdata)
    );

    // ---------------------------------------------------------------------
    // Next state and control
    // ---------------------------------------------------------------------
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        issue_next     = issue_reg;
        div_cnt_next   = div_cnt_reg;
        inten_next     = inten_reg;
        best_next      = best_reg;
        best_idx_next  = best_idx_reg;
        found_next     = found_reg;
        rsp_valid_next = rsp_valid_reg;
        chroma_next    = chroma_reg;
        inten_out_next = inten_out_reg;
        nomatch_next   = nomatch_reg;

        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_LOAD:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == LAST_IDX)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    // black maps to intensity 1 so the divide is defined
                    inten_next   = (max_rgb == '0) ? COMP_W'(1) : max_rgb;
                    div_cnt_next = '0;
                    state_next   = ST_DIV;
                end
            end
            ST_DIV:
            begin
                div_cnt_next = div_cnt_reg + 1'b1;
                if (div_cnt_reg == DIV_CW'(DIV_STEPS - 1))
                begin
                    state_next    = ST_SEARCH;
                    issue_next    = 1'b1;
                    cnt_next      = '0;
                    best_next     = BEST_W'(TBL_DEPTH);
                    best_idx_next = '0;
                    found_next    = 1'b0;
                end
            end
            ST_SEARCH:
            begin
                if (issue_reg)
                begin
                    cnt_next = cnt_reg + 1'b1;
                    if (cnt_reg == LAST_IDX)
                    begin
                        issue_next = 1'b0;
                    end
                end
                // strict less-than keeps the lowest index on ties
                if (fin_v && (fin_dist < best_reg))
                begin
                    best_next     = fin_dist;
                    best_idx_next = rt_idx_reg[SQ_STAGES-1];
                    found_next    = 1'b1;
                end
                if (fin_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_valid_next = 1'b1;
                    // index is row*16+column; chroma byte is column<<4 | row
                    chroma_next    = found_reg ?
                                     {best_idx_reg[3:0], best_idx_reg[7:4]} : '0;
                    inten_out_next = inten_reg;
                    nomatch_next   = !found_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ---------------------------------------------------------------------
    // Divider lanes
    // ---------------------------------------------------------------------
    always_comb
    begin
        for (int l = 0; l < 3; l++)
        begin
            rem_next[l] = rem_reg[l];
            low_next[l] = low_reg[l];
            quo_next[l] = quo_reg[l];
            dvd[l]      = {comp[l], COMP_W'(0)} - {COMP_W'(0), comp[l]};
            rem9[l]     = {rem_reg[l], low_reg[l][COMP_W-1]};
            if (req_valid && req_ready)
            begin
                rem_next[l] = dvd[l][RAD_W-1:COMP_W];
                low_next[l] = dvd[l][COMP_W-1:0];
            end
            else if (state_reg == ST_DIV)
            begin
                low_next[l] = {low_reg[l][COMP_W-2:0], 1'b0};
                if (rem9[l] >= {1'b0, inten_reg})
                begin
                    rem_next[l] = COMP_W'(rem9[l] - {1'b0, inten_reg});
                    quo_next[l] = {quo_reg[l][COMP_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next[l] = rem9[l][COMP_W-1:0];
                    quo_next[l] = {quo_reg[l][COMP_W-2:0], 1'b0};
                end
            end
        end
    end

    // ---------------------------------------------------------------------
    // Distance pipeline
    // ---------------------------------------------------------------------
    always_comb
    begin
        rd_v_next    = issue_v;
        rd_last_next = (cnt_reg == LAST_IDX);
        rd_idx_next  = cnt_reg;

        mul_v_next    = rd_v_reg;
        mul_last_next = rd_last_reg;
        mul_idx_next  = rd_idx_reg;
        for (int l = 0; l < 3; l++)
        begin
            ent[l]  = ram_rdata[(2 - l) * COMP_W +: COMP_W];
            diff[l] = (ent[l] > quo_reg[l]) ? (ent[l] - quo_reg[l])
                                            : (quo_reg[l] - ent[l]);
            mul_sq_next[l] = RAD_W'(diff[l]) * RAD_W'(diff[l]);
        end

        sum_full      = (RAD_W + 2)'(mul_sq_reg[0]) + (RAD_W + 2)'(mul_sq_reg[1])
                      + (RAD_W + 2)'(mul_sq_reg[2]);
        sum_v_next    = mul_v_reg;
        sum_last_next = mul_last_reg;
        sum_idx_next  = mul_idx_reg;
        sum_big_next  = |sum_full[RAD_W+1:RAD_W];
        sum_val_next  = sum_full[RAD_W-1:0];

        // bit-pair square root, one result bit per stage
        for (int k = 0; k < SQ_STAGES; k++)
        begin
            logic [RAD_W-1:0] in_rem;
            logic [RAD_W:0]   in_root;
            logic [RAD_W:0]   bitk;
            logic [RAD_W:0]   trial;
            if (k == 0)
            begin
                rt_v_next[k]    = sum_v_reg;
                rt_last_next[k] = sum_last_reg;
                rt_idx_next[k]  = sum_idx_reg;
                rt_big_next[k]  = sum_big_reg;
                in_rem          = sum_val_reg;
                in_root         = '0;
            end
            else
            begin
                rt_v_next[k]    = rt_v_reg[k-1];
                rt_last_next[k] = rt_last_reg[k-1];
                rt_idx_next[k]  = rt_idx_reg[k-1];
                rt_big_next[k]  = rt_big_reg[k-1];
                in_rem          = rt_rem_reg[k-1];
                in_root         = rt_root_reg[k-1];
            end
            bitk  = (RAD_W + 1)'(1) << (2 * (SQ_STAGES - 1 - k));
            trial = in_root + bitk;
            if ({1'b0, in_rem} >= trial)
            begin
                rt_rem_next[k]  = in_rem - trial[RAD_W-1:0];
                rt_root_next[k] = (in_root >> 1) + bitk;
            end
            else
            begin
                rt_rem_next[k]  = in_rem;
                rt_root_next[k] = in_root >> 1;
            end
        end
    end

    // ---------------------------------------------------------------------
    // Control registers
    // ---------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            cnt_reg       <= '0;
            issue_reg     <= 1'b0;
            div_cnt_reg   <= '0;
            rd_v_reg      <= 1'b0;
            mul_v_reg     <= 1'b0;
            sum_v_reg     <= 1'b0;
            for (int k = 0; k < SQ_STAGES; k++)
            begin
                rt_v_reg[k] <= 1'b0;
            end
            found_reg     <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            issue_reg     <= issue_next;
            div_cnt_reg   <= div_cnt_next;
            rd_v_reg      <= rd_v_next;
            mul_v_reg     <= mul_v_next;
            sum_v_reg     <= sum_v_next;
            for (int k = 0; k < SQ_STAGES; k++)
            begin
                rt_v_reg[k] <= rt_v_next[k];
            end
            found_reg     <= found_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // ---------------------------------------------------------------------
    // Payload registers
    // ---------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        inten_reg     <= inten_next;
        for (int l = 0; l < 3; l++)
        begin
            rem_reg[l]    <= rem_next[l];
            low_reg[l]    <= low_next[l];
            quo_reg[l]    <= quo_next[l];
            mul_sq_reg[l] <= mul_sq_next[l];
        end
        rd_last_reg   <= rd_last_next;
        rd_idx_reg    <= rd_idx_next;
        mul_last_reg  <= mul_last_next;
        mul_idx_reg   <= mul_idx_next;
        sum_last_reg  <= sum_last_next;
        sum_idx_reg   <= sum_idx_next;
        sum_big_reg   <= sum_big_next;
        sum_val_reg   <= sum_val_next;
        for (int k = 0; k < SQ_STAGES; k++)
        begin
            rt_last_reg[k] <= rt_last_next[k];
            rt_idx_reg[k]  <= rt_idx_next[k];
            rt_big_reg[k]  <= rt_big_next[k];
            rt_rem_reg[k]  <= rt_rem_next[k];
            rt_root_reg[k] <= rt_root_next[k];
        end
        best_reg      <= best_next;
        best_idx_reg  <= best_idx_next;
        chroma_reg    <= chroma_next;
        inten_out_reg <= inten_out_next;
        nomatch_reg   <= nomatch_next;
    end

    assign rsp_valid   = rsp_valid_reg;
    assign chroma_byte = chroma_reg;
    assign intensity   = inten_out_reg;
    assign no_match    = nomatch_reg;

endmodule
